[rtl/apgc_pkg.sv]
package apgc_pkg;

    localparam int FRAME_DEPTH_DEF   = 64;
    localparam int HISTORY_DEPTH_DEF = 512;
    localparam int GAIN_FRAC_DEF     = 10;

    localparam int SAMPLE_W        = 16;
    localparam int SAMPLE_MAX      = 32767;
    localparam int SAMPLE_MIN      = -32768;
    localparam int FULL_SCALE_LOG2 = 15;
    localparam int ACC_FRAC        = 16;
    localparam int DEN_W           = 16;
    localparam int GAIN_INT_W      = 6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_ANTICLIP = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_GAIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIST_LEN = 3'd4;

    localparam logic        RST_ANTICLIP = 1'b1;
    localparam logic [14:0] RST_TARGET   = 15'd25000;
    localparam logic [5:0]  RST_MAX_GAIN = 6'd32;
    localparam logic [3:0]  RST_SMOOTH   = 4'd8;
    localparam logic [9:0]  RST_HIST_LEN = 10'd400;

endpackage

[rtl/apgc_divider.sv]
module apgc_divider #(
    parameter int NW = 32,
    parameter int DW = apgc_pkg::DEN_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/apgc_scaler.sv]
module apgc_scaler #(
    parameter int GW = 16,
    parameter int F  = 10
) (
    input  logic                 aclk,
    input  logic signed [15:0]   sample,
    input  logic [GW-1:0]        gain,
    output logic signed [15:0]   scaled,
    output logic                 clipped
);

    localparam int PRW = GW + 17;
    localparam logic signed [PRW-1:0] LIM_HI = PRW'(apgc_pkg::SAMPLE_MAX);
    localparam logic signed [PRW-1:0] LIM_LO = PRW'(apgc_pkg::SAMPLE_MIN);

    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] shifted;

    always_ff @(posedge aclk) begin
        prod_reg <= PRW'(sample) * PRW'($signed({1'b0, gain}));
    end

    assign shifted = prod_reg >>> F;

    always_comb begin
        if (shifted > LIM_HI) begin
            scaled  = 16'sh7FFF;
            clipped = 1'b1;
        end else if (shifted < LIM_LO) begin
            scaled  = 16'sh8000;
            clipped = 1'b1;
        end else begin
            scaled  = shifted[15:0];
            clipped = 1'b0;
        end
    end

endmodule

[rtl/audio_peak_gain_compressor.sv]
// Peak-driven automatic gain control on frames of signed 16-bit samples. Samples of a frame
// are taken one per cycle until frame_end or until FRAME_DEPTH samples are buffered; the block
// then runs a per-frame pass and takes no samples until the last result of the frame is
// taken. The pass uses one shared restoring divider and runs, in order: the ring slot modulo
// (not on the first frame), the history scan, three divisions for the gains and the ramp
// rate with control steps among them, then per output sample a read, multiply, load and
// hand off, the last of which waits out any output stall. After reset all HISTORY_DEPTH
// entries of the history ring are cleared, and a write that lengthens the ring clears the
// newly used entries; input waits meanwhile while configuration writes are taken as usual.
module audio_peak_gain_compressor #(
    parameter int FRAME_DEPTH        = apgc_pkg::FRAME_DEPTH_DEF,
    parameter int HISTORY_DEPTH      = apgc_pkg::HISTORY_DEPTH_DEF,
    parameter int GAIN_FRACTION_BITS = apgc_pkg::GAIN_FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [15:0]                s_sample_in,
    input  logic                              s_frame_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [15:0]                m_sample_out,
    output logic                              m_was_clipped,
    output logic                              m_frame_last,
    input  logic                              cfg_we,
    input  logic [apgc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [apgc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int F   = GAIN_FRACTION_BITS;
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int CW  = $clog2(FRAME_DEPTH + 1);
    localparam int PW  = CW + 1;
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LW  = $clog2(HISTORY_DEPTH + 1);
    localparam int GW  = F + apgc_pkg::GAIN_INT_W;
    localparam int NW  = GW + apgc_pkg::ACC_FRAC;
    localparam int AW  = NW + 1;
    localparam int DW  = apgc_pkg::DEN_W;

    localparam logic [NW-1:0] UNITY_N = {{(NW-1){1'b0}}, 1'b1} << F;
    localparam logic [NW-1:0] CLIP_N  = {{(NW-1){1'b0}}, 1'b1} << (F + apgc_pkg::FULL_SCALE_LOG2);
    localparam logic [GW-1:0] UNITY_G = {{(GW-1){1'b0}}, 1'b1} << F;

    typedef enum logic [17:0] {
        S_LOAD   = 18'h00001,
        S_MOD    = 18'h00002,
        S_MOD_W  = 18'h00004,
        S_WRITE  = 18'h00008,
        S_SCAN   = 18'h00010,
        S_G1     = 18'h00020,
        S_G1_W   = 18'h00040,
        S_SM_A   = 18'h00080,
        S_SM_B   = 18'h00100,
        S_G2     = 18'h00200,
        S_G2_W   = 18'h00400,
        S_DECIDE = 18'h00800,
        S_RATE   = 18'h01000,
        S_RATE_W = 18'h02000,
        S_RD     = 18'h04000,
        S_MUL    = 18'h08000,
        S_OUT    = 18'h10000,
        S_WAIT   = 18'h20000
    } state_t;

    function automatic logic [LW-1:0] ring_len(input logic [9:0] v);
        if (v == 10'd0) return LW'(1);
        if (int'(v) > HISTORY_DEPTH) return LW'(HISTORY_DEPTH);
        return LW'(v);
    endfunction

    state_t state_reg, state_next;

    logic        anticlip_reg;
    logic [14:0] target_reg;
    logic [5:0]  max_gain_reg;
    logic [3:0]  shift_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] new_len;

    logic          clr_active_reg;
    logic [LW-1:0] clr_ptr_reg;
    logic [LW-1:0] clr_end_reg;

    logic signed [15:0] frame_mem [FRAME_DEPTH];
    logic signed [15:0] frame_rdata;
    logic [15:0]        hist_mem [HISTORY_DEPTH];
    logic [15:0]        hist_rdata;

    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  n_reg;
    logic [15:0]    peak_reg;
    logic [FAW-1:0] ppos_reg;
    logic           started_reg;
    logic [HAW-1:0] slot_reg;

    logic [LW-1:0]  scan_idx_reg;
    logic           rd_vld_reg;
    logic [15:0]    best_reg;
    logic [FAW-1:0] best_pos_reg;

    logic [NW-1:0] gn1_reg;
    logic [NW-1:0] gn2_reg;
    logic [NW-1:0] sum_reg;
    logic [GW-1:0] goal_reg;
    logic [GW-1:0] now_reg;
    logic [PW-1:0] pos_reg;
    logic          neg_reg;
    logic signed [AW-1:0] rate_reg;
    logic signed [AW-1:0] acc_reg;
    logic [FAW-1:0] idx_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_sample_reg;
    logic               m_clip_reg;
    logic               m_last_reg;

    logic          s_acc;
    logic          frame_done;
    logic signed [16:0] s_ext;
    logic [16:0]   abs_wide;
    logic [15:0]   peak_base;
    logic          last_sample;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    logic signed [GW:0] rate_diff;
    logic [GW-1:0]      rate_mag;
    logic [NW-1:0]      sm_shift;
    logic [NW-1:0]      sm_adj;
    logic [GW-1:0]      max_goal;
    logic [PW-1:0]      decide_pos;
    logic               gn2_lower;

    logic signed [15:0] sc_out;
    logic               sc_clip;

    assign s_ready   = (state_reg == S_LOAD) && !clr_active_reg;
    assign s_acc     = s_valid && s_ready;
    assign s_ext     = s_sample_in;
    assign abs_wide  = s_sample_in[15] ? 17'(-s_ext) : 17'(s_ext);
    assign peak_base = (cnt_reg == '0) ? 16'd1 : peak_reg;
    assign frame_done = s_frame_end || (cnt_reg == CW'(FRAME_DEPTH - 1));
    assign last_sample = (CW'(idx_reg) + CW'(1) == n_reg);
    assign new_len   = ring_len(cfg_wdata[9:0]);

    assign rate_diff = $signed({1'b0, goal_reg}) - $signed({1'b0, now_reg});
    assign rate_mag  = rate_diff[GW] ? GW'(-rate_diff) : rate_diff[GW-1:0];
    assign sm_shift  = sum_reg >> shift_reg;
    assign max_goal  = GW'(max_gain_reg) << F;
    assign gn2_lower = (gn2_reg < NW'(goal_reg));

    always_comb begin
        if (gn1_reg < sm_shift) begin
            sm_adj = sm_shift - NW'(1);
        end else if (gn1_reg > sm_shift) begin
            sm_adj = sm_shift + NW'(1);
        end else begin
            sm_adj = sm_shift;
        end
    end

    always_comb begin
        if (gn2_lower) begin
            decide_pos = anticlip_reg ? '0 : PW'(best_pos_reg);
        end else begin
            decide_pos = {n_reg, 1'b0};
        end
        if (decide_pos == '0) begin
            decide_pos = PW'(1);
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = best_reg;
        case (state_reg)
            S_MOD: begin
                div_start = started_reg;
                div_num   = NW'(slot_reg) + NW'(1);
                div_den   = DW'(len_reg);
            end
            S_G1: begin
                div_start = 1'b1;
                div_num   = NW'(target_reg) << F;
            end
            S_G2: begin
                div_start = 1'b1;
                div_num   = CLIP_N;
            end
            S_RATE: begin
                div_start = 1'b1;
                div_num   = NW'(rate_mag) << apgc_pkg::ACC_FRAC;
                div_den   = DW'(pos_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:   if (s_acc && frame_done) state_next = S_MOD;
            S_MOD:    state_next = started_reg ? S_MOD_W : S_WRITE;
            S_MOD_W:  if (div_done) state_next = S_WRITE;
            S_WRITE:  state_next = S_SCAN;
            S_SCAN:   if (scan_idx_reg == len_reg && !rd_vld_reg) state_next = S_G1;
            S_G1:     state_next = S_G1_W;
            S_G1_W:   if (div_done) state_next = S_SM_A;
            S_SM_A:   state_next = S_SM_B;
            S_SM_B:   state_next = S_G2;
            S_G2:     state_next = S_G2_W;
            S_G2_W:   if (div_done) state_next = S_DECIDE;
            S_DECIDE: state_next = S_RATE;
            S_RATE:   state_next = S_RATE_W;
            S_RATE_W: if (div_done) state_next = S_RD;
            S_RD:     state_next = S_MUL;
            S_MUL:    state_next = S_OUT;
            S_OUT:    state_next = S_WAIT;
            S_WAIT: begin
                if (m_ready) state_next = last_sample ? S_LOAD : S_RD;
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            cnt_reg        <= '0;
            started_reg    <= 1'b0;
            slot_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_ptr_reg    <= '0;
            clr_end_reg    <= LW'(HISTORY_DEPTH);
            anticlip_reg   <= apgc_pkg::RST_ANTICLIP;
            target_reg     <= apgc_pkg::RST_TARGET;
            max_gain_reg   <= apgc_pkg::RST_MAX_GAIN;
            shift_reg      <= apgc_pkg::RST_SMOOTH;
            len_reg        <= ring_len(apgc_pkg::RST_HIST_LEN);
            now_reg        <= UNITY_G;
            goal_reg       <= UNITY_G;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (clr_active_reg) begin
                clr_ptr_reg <= clr_ptr_reg + LW'(1);
                if (clr_ptr_reg + LW'(1) == clr_end_reg) clr_active_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_addr)
                    apgc_pkg::REG_ANTICLIP: anticlip_reg <= cfg_wdata[0];
                    apgc_pkg::REG_TARGET:   target_reg   <= cfg_wdata[14:0];
                    apgc_pkg::REG_MAX_GAIN: max_gain_reg <= cfg_wdata[5:0];
                    apgc_pkg::REG_SMOOTH:   shift_reg    <= cfg_wdata[3:0];
                    apgc_pkg::REG_HIST_LEN: begin
                        len_reg <= new_len;
                        if (new_len > len_reg) begin
                            clr_active_reg <= 1'b1;
                            clr_ptr_reg <= (clr_active_reg && clr_ptr_reg < len_reg) ?
                                           clr_ptr_reg : len_reg;
                            clr_end_reg <= (clr_active_reg && clr_end_reg > new_len) ?
                                           clr_end_reg : new_len;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (s_acc) cnt_reg <= frame_done ? '0 : cnt_reg + CW'(1);

            case (state_reg)
                S_MOD: begin
                    if (!started_reg) begin
                        started_reg <= 1'b1;
                        slot_reg    <= '0;
                    end
                end
                S_MOD_W:  if (div_done) slot_reg <= div_rem[HAW-1:0];
                S_SM_B:   goal_reg <= (sm_adj > NW'(max_goal)) ? max_goal : sm_adj[GW-1:0];
                S_DECIDE: if (gn2_lower) goal_reg <= gn2_reg[GW-1:0];
                S_RD:     now_reg <= acc_reg[GW+15:16];
                S_OUT:    m_valid_reg <= 1'b1;
                S_WAIT:   if (m_ready) m_valid_reg <= 1'b0;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            frame_mem[cnt_reg[FAW-1:0]] <= s_sample_in;
            if (abs_wide[15:0] > peak_base) begin
                peak_reg <= abs_wide[15:0];
                ppos_reg <= cnt_reg[FAW-1:0];
            end else begin
                peak_reg <= peak_base;
                if (cnt_reg == '0) ppos_reg <= '0;
            end
            if (frame_done) n_reg <= cnt_reg + CW'(1);
        end
        frame_rdata <= frame_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            hist_mem[clr_ptr_reg[HAW-1:0]] <= '0;
        end else if (state_reg == S_WRITE) begin
            hist_mem[slot_reg] <= peak_reg;
        end
        if (scan_idx_reg < len_reg) hist_rdata <= hist_mem[scan_idx_reg[HAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_WRITE: begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
                best_reg     <= peak_reg;
                best_pos_reg <= ppos_reg;
            end
            S_SCAN: begin
                rd_vld_reg <= (scan_idx_reg < len_reg);
                if (scan_idx_reg < len_reg) scan_idx_reg <= scan_idx_reg + LW'(1);
                if (rd_vld_reg && hist_rdata > best_reg) begin
                    best_reg     <= hist_rdata;
                    best_pos_reg <= '0;
                end
            end
            S_G1_W:   if (div_done) gn1_reg <= (div_quo < UNITY_N) ? UNITY_N : div_quo;
            S_SM_A:   sum_reg <= (NW'(goal_reg) << shift_reg) - NW'(goal_reg) + gn1_reg;
            S_G2_W:   if (div_done) gn2_reg <= div_quo;
            S_DECIDE: pos_reg <= decide_pos;
            S_RATE:   neg_reg <= rate_diff[GW];
            S_RATE_W: begin
                if (div_done) begin
                    rate_reg <= neg_reg ? -AW'(div_quo) : AW'(div_quo);
                    acc_reg  <= {1'b0, now_reg, 16'b0};
                    idx_reg  <= '0;
                end
            end
            S_RD: begin
                if (PW'(idx_reg) < pos_reg) begin
                    acc_reg <= acc_reg + rate_reg;
                end else if (PW'(idx_reg) == pos_reg) begin
                    acc_reg <= {1'b0, goal_reg, 16'b0};
                end
            end
            S_OUT: begin
                m_sample_reg <= sc_out;
                m_clip_reg   <= sc_clip;
                m_last_reg   <= last_sample;
            end
            S_WAIT:   if (m_ready && !last_sample) idx_reg <= idx_reg + FAW'(1);
            default: begin
            end
        endcase
    end

    apgc_divider #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numer     (div_num),
        .denom     (div_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    apgc_scaler #(
        .GW(GW),
        .F (F)
    ) u_scaler (
        .aclk    (aclk),
        .sample  (frame_rdata),
        .gain    (now_reg),
        .scaled  (sc_out),
        .clipped (sc_clip)
    );

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_was_clipped = m_clip_reg;
    assign m_frame_last  = m_last_reg;

endmodule
